### rtl/sparse_lower_triangular_solve_macros.svh
// Assertion macros for the sparse lower-triangular solver.
`ifndef SPARSE_LOWER_TRIANGULAR_SOLVE_MACROS_SVH
`define SPARSE_LOWER_TRIANGULAR_SOLVE_MACROS_SVH
`ifndef SYNTHESIS
`define SLTS_ASSERT_NOW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define SLTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SLTS_ASSERT_NOW(lbl, expr, msg)
`define SLTS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/slts_pkg.sv
// Shared constants, types and control structs of the sparse lower-triangular solver.
`timescale 1ns / 1ps
package slts_pkg;

  localparam int MAX_ROWS   = 1024;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int CNT_W      = ROW_W + 1;
  localparam int VAL_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int ACC_W      = 2 * VAL_W;
  localparam int DIV_STEPS  = VAL_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int IN_DATA_W  = ((ROW_W + 2 * VAL_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ROW_W + VAL_W + 7) / 8) * 8;
  localparam int OUT_USER_W = 2;
  localparam logic [CNT_W-1:0] ROW_COUNT_RESET = CNT_W'(MAX_ROWS);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DECODE = 9'b000000010,
    ST_READ   = 9'b000000100,
    ST_MUL    = 9'b000001000,
    ST_ACC    = 9'b000010000,
    ST_NUMER  = 9'b000100000,
    ST_PREP   = 9'b001000000,
    ST_DIV    = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_t;

  typedef struct packed {
    logic accept;
    logic set_diag;
    logic mem_read;
    logic mul;
    logic acc;
    logic numer;
    logic prep;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic has_entry;
    logic off_diag;
    logic row_end;
    logic diag_zero;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

### rtl/slts_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module slts_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [slts_pkg::ACC_W-1:0] num,
  input  logic [slts_pkg::VAL_W-1:0] den,
  output logic                       done,
  output logic [slts_pkg::VAL_W-1:0] quot
);
  import slts_pkg::*;

  logic [VAL_W-1:0]  rem;
  logic [VAL_W-1:0]  sh;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic [VAL_W:0]    trial;
  logic [VAL_W:0]    diff;
  logic              ge;

  always_comb begin
    trial = {rem, sh[VAL_W-1]};
    diff  = trial - {1'b0, den};
    ge    = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == STEP_W'(DIV_STEPS - 1));
      if (busy) begin
        cnt <= cnt + STEP_W'(1);
        if (cnt == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[ACC_W-1:VAL_W];
      sh  <= num[VAL_W-1:0];
    end else if (busy) begin
      rem <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
      sh  <= {sh[VAL_W-2:0], ge};
    end
  end

  assign quot = sh;

endmodule

### rtl/slts_ctrl.sv
// Controller state machine of the sparse lower-triangular solver.
`timescale 1ns / 1ps
module slts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  slts_pkg::status_t status,
  output slts_pkg::cmd_t    cmd
);
  import slts_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.has_entry && status.off_diag) begin
          state_next = ST_READ;
        end else begin
          cmd.set_diag = status.has_entry;
          state_next   = status.row_end ? ST_NUMER : ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.mem_read = 1'b1;
        state_next   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = status.row_end ? ST_NUMER : ST_IDLE;
      end
      ST_NUMER: begin
        cmd.numer  = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = status.diag_zero ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = status.out_free;
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/slts_datapath.sv
// Datapath: input latch, solution memory, multiply-accumulate, quotient and output word.
`timescale 1ns / 1ps
module slts_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [slts_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tuser,
  input  logic                            s_tlast,
  input  logic                            cfg_we,
  input  logic [slts_pkg::CNT_W-1:0]      cfg_data,
  input  slts_pkg::cmd_t                  cmd,
  output slts_pkg::status_t               status,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [slts_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [slts_pkg::OUT_USER_W-1:0] m_tuser
);
  import slts_pkg::*;

  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};

  logic [ROW_W-1:0]        col_r;
  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] rhs_r;
  logic                    has_r;
  logic                    end_r;

  logic [VAL_W-1:0]        mem [MAX_ROWS];
  logic [VAL_W-1:0]        rd_data;

  logic [ROW_W-1:0]        cur_row;
  logic [CNT_W-1:0]        row_count;
  logic signed [ACC_W-1:0] acc;
  logic signed [VAL_W-1:0] diag;
  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] num;
  logic                    neg_r;
  logic                    ovf_r;

  logic signed [ACC_W-1:0] prod_c;
  logic signed [ACC_W:0]   sum_c;
  logic signed [ACC_W-1:0] acc_c;
  logic signed [ACC_W:0]   rhs_ext;
  logic signed [ACC_W:0]   diff_c;
  logic signed [ACC_W-1:0] num_c;
  logic [ACC_W-1:0]        mn_c;
  logic [VAL_W-1:0]        md_c;
  logic                    div_done;
  logic [VAL_W-1:0]        quot;
  logic [VAL_W-1:0]        sol;
  logic                    sat;
  logic                    sing;
  logic [CNT_W-1:0]        eff_rows;
  logic [CNT_W-1:0]        row_inc;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      col_r <= s_tdata[ROW_W-1:0];
      val_r <= s_tdata[ROW_W+VAL_W-1:ROW_W];
      rhs_r <= s_tdata[ROW_W+2*VAL_W-1:ROW_W+VAL_W];
      has_r <= s_tuser;
      end_r <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      rd_data <= mem[col_r];
    end
    if (cmd.finish) begin
      mem[cur_row] <= sol;
    end
  end

  always_comb begin
    prod_c  = val_r * $signed(rd_data);
    sum_c   = {acc[ACC_W-1], acc} + {prod[ACC_W-1], prod};
    if (sum_c[ACC_W] != sum_c[ACC_W-1]) begin
      acc_c = sum_c[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_c = sum_c[ACC_W-1:0];
    end
    rhs_ext = {{(ACC_W+1-VAL_W-FRAC_W){rhs_r[VAL_W-1]}}, rhs_r, {FRAC_W{1'b0}}};
    diff_c  = rhs_ext - {acc[ACC_W-1], acc};
    if (diff_c[ACC_W] != diff_c[ACC_W-1]) begin
      num_c = diff_c[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      num_c = diff_c[ACC_W-1:0];
    end
    mn_c = num[ACC_W-1] ? (~num + ACC_W'(1)) : num;
    md_c = diag[VAL_W-1] ? (~diag + VAL_W'(1)) : diag;
  end

  slts_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.prep && (diag != '0)),
    .num   (mn_c),
    .den   (md_c),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= prod_c;
    end
    if (cmd.numer) begin
      num <= num_c;
    end
    if (cmd.prep) begin
      neg_r <= num[ACC_W-1] ^ diag[VAL_W-1];
      ovf_r <= mn_c >= {md_c, {VAL_W{1'b0}}};
    end
  end

  // quotient below 2^VAL_W unless ovf_r, then clip to the signed range
  always_comb begin
    sing = (diag == '0);
    sat  = 1'b0;
    sol  = '0;
    if (!sing) begin
      if (neg_r) begin
        sat = ovf_r || (quot > VAL_MIN);
        sol = sat ? VAL_MIN : (~quot + VAL_W'(1));
      end else begin
        sat = ovf_r || quot[VAL_W-1];
        sol = sat ? VAL_MAX : quot;
      end
    end
  end

  always_comb begin
    if (row_count == '0) begin
      eff_rows = CNT_W'(1);
    end else if (row_count > CNT_W'(MAX_ROWS)) begin
      eff_rows = CNT_W'(MAX_ROWS);
    end else begin
      eff_rows = row_count;
    end
    row_inc = {1'b0, cur_row} + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= ROW_COUNT_RESET;
    end else if (cfg_we) begin
      row_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      diag     <= '0;
      cur_row  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.set_diag) begin
        diag <= val_r;
      end
      if (cmd.acc) begin
        acc <= acc_c;
      end
      if (cmd.finish) begin
        acc      <= '0;
        diag     <= '0;
        cur_row  <= (row_inc >= eff_rows) ? '0 : row_inc[ROW_W-1:0];
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {{(OUT_DATA_W-ROW_W-VAL_W){1'b0}}, sol, cur_row};
      m_tuser <= {sat, sing};
    end
  end

  always_comb begin
    status.has_entry = has_r;
    status.off_diag  = col_r < cur_row;
    status.row_end   = end_r;
    status.diag_zero = (diag == '0);
    status.div_done  = div_done;
    status.out_free  = !m_tvalid || m_tready;
  end

endmodule

### rtl/sparse_lower_triangular_solve.sv
// Sparse lower-triangular forward substitution, rows streamed in compressed-row order.
// Input words (s_*) carry one nonzero of the current row: column and value in
// s_tdata, s_tuser high when the word holds an entry, s_tlast closing the row
// with its right-hand side. An entry left of the diagonal is multiplied by the
// stored solution of its column and summed; any other entry sets the diagonal.
// Each row end yields one output word (m_*): row index and Q16.16 solution,
// with singular and saturated flags in m_tuser.
// One word is in work at a time. A word without a row end is accepted and
// decoded; one with an off-diagonal entry also goes through memory read,
// multiply and accumulate. A row end adds numerator, operand prep, the 32-step
// restoring divider and the output load; a singular row skips
// the divider. The result is in m_tdata the cycle after the load.
// The output register lets the next word be taken while a result waits; if
// m_tready stays low, the next row end holds in its final step until the
// register frees. cfg_we writes row_count; write only while the block is idle.
// Reset clears the row counter, sum and diagonal and sets row_count to 1024;
// the solution memory is not cleared.
`timescale 1ns / 1ps
`include "sparse_lower_triangular_solve_macros.svh"
module sparse_lower_triangular_solve (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [slts_pkg::IN_DATA_W-1:0]  s_tdata,  // column, value, rhs, zero pad
  input  logic                            s_tuser,  // has_entry
  input  logic                            s_tlast,  // row_end
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [slts_pkg::OUT_DATA_W-1:0] m_tdata,  // row_index, solution, zero pad
  output logic [slts_pkg::OUT_USER_W-1:0] m_tuser,  // singular, saturated
  input  logic                            cfg_we,
  input  logic [slts_pkg::CNT_W-1:0]      cfg_data
);
  import slts_pkg::*;

  cmd_t    cmd;
  status_t status;

  slts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  slts_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  `SLTS_ASSERT_NOW(a_load_when_free, !cmd.finish || status.out_free, "result loaded over a pending word")
  `SLTS_ASSERT_NEXT(a_load_shows, cmd.finish, m_tvalid, "loaded result not presented")
  `SLTS_ASSERT_NOW(a_accept_excl, !(cmd.accept && (cmd.finish || cmd.acc)), "word accepted mid-row")
  `SLTS_ASSERT_NEXT(a_busy_after_prep, cmd.prep, !s_tready, "input taken before result")

endmodule
